### rtl/edfs_pkg.sv
// ----------------------------------------------------------------------------
// edfs_pkg
// Shared types and constants for the EDF unit slot scheduler.
// ----------------------------------------------------------------------------
package edfs_pkg;

  localparam int unsigned EDFS_DEPTH     = 64;
  localparam int unsigned SLOT_W         = 16;
  localparam int unsigned OUT_W          = 7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_EMIT,
    ST_EMPTY
  } sched_state_e;

endpackage

### rtl/edf_unit_slot_scheduler.sv
// ----------------------------------------------------------------------------
// edf_unit_slot_scheduler
// Earliest-deadline-first scheduler over unit time slots, one shared
// compare unit stepping through the task store.
//
// Usage: a task word is taken at a rising edge with start high and busy low.
// Words without last_task_i are stored (up to DEPTH; later ones dropped) and
// busy stays low. A word with last_task_i starts a run: busy rises and stays
// high until the last result has been issued. Results appear one per cycle
// on task_number_o / scheduled_count_o / final_result_o, each marked by a
// one-cycle result_strobe_o; the receiver must take them as they come.
// Flow of a run over n stored tasks: each slot scans all n entries through
// the store read port, then the chosen list is read out at one result per
// cycle. A run that stops at a slot it cannot fill scans that slot too; a
// run that fills nothing gives one result with task 0. Reset clears the
// control state and the task count; the stores need no clearing, as each
// entry is written when its task is loaded.
// ----------------------------------------------------------------------------
module edf_unit_slot_scheduler
  import edfs_pkg::*;
#(
  parameter int unsigned DEPTH = EDFS_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [SLOT_W-1:0] release_slot_i,
  input  logic [SLOT_W-1:0] deadline_slot_i,
  input  logic              last_task_i,
  output logic              result_strobe_o,
  output logic [OUT_W-1:0]  task_number_o,
  output logic [OUT_W-1:0]  scheduled_count_o,
  output logic              final_result_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);

  logic [SLOT_W-1:0] rel_mem    [DEPTH];
  logic [SLOT_W-1:0] dl_mem     [DEPTH];
  logic              used_mem   [DEPTH];
  logic [CW-1:0]     chosen_mem [DEPTH];

  sched_state_e state_q, state_d;

  logic [CW-1:0]     count_q;
  logic [CW-1:0]     slot_q;
  logic [CW-1:0]     filled_q;
  logic [CW-1:0]     scan_q;
  logic [CW-1:0]     emit_q;
  logic [AW-1:0]     rd_idx_q;
  logic              rd_v_q;
  logic [SLOT_W-1:0] rel_rd_q;
  logic [SLOT_W-1:0] dl_rd_q;
  logic              used_rd_q;
  logic              found_q;
  logic [AW-1:0]     best_idx_q;
  logic [SLOT_W-1:0] best_rel_q;
  logic [SLOT_W-1:0] best_dl_q;
  logic [CW-1:0]     chosen_rd_q;
  logic              strobe_q;
  logic              final_q;
  logic              empty_q;

  logic              accept;
  logic              store_en;
  logic [SLOT_W-1:0] slot_ext;
  logic              cand_ok;
  logic              better;
  logic              scan_rd;
  logic              emit_rd;
  logic              emit_last;
  logic [CW+OUT_W-1:0] task_ext;
  logic [CW+OUT_W-1:0] count_ext;

  assign accept    = start && !busy;
  assign store_en  = accept && (count_q < DepthC);
  assign slot_ext  = SLOT_W'(slot_q);
  assign scan_rd   = (state_q == ST_SCAN) && (scan_q < count_q);
  assign emit_rd   = (state_q == ST_EMIT);
  assign emit_last = (emit_q + 1'b1 == filled_q);

  assign cand_ok = rd_v_q && !used_rd_q && (rel_rd_q <= slot_ext) && (dl_rd_q >= slot_ext);
  assign better  = !found_q || (dl_rd_q < best_dl_q) ||
                   ((dl_rd_q == best_dl_q) && (rel_rd_q >= best_rel_q));

  // task store and used marks
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      rel_mem[count_q[AW-1:0]] <= release_slot_i;
      dl_mem[count_q[AW-1:0]]  <= deadline_slot_i;
    end
    if (store_en) begin
      used_mem[count_q[AW-1:0]] <= 1'b0;
    end else if ((state_q == ST_PICK) && found_q) begin
      used_mem[best_idx_q] <= 1'b1;
    end
    rel_rd_q  <= rel_mem[scan_q[AW-1:0]];
    dl_rd_q   <= dl_mem[scan_q[AW-1:0]];
    used_rd_q <= used_mem[scan_q[AW-1:0]];
  end

  // chosen list
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_PICK) && found_q) begin
      chosen_mem[filled_q[AW-1:0]] <= CW'(best_idx_q) + 1'b1;
    end
    chosen_rd_q <= chosen_mem[emit_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cand_ok && better) begin
      best_idx_q <= rd_idx_q;
      best_rel_q <= rel_rd_q;
      best_dl_q  <= dl_rd_q;
    end
    rd_idx_q <= scan_q[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
    end else begin
      state_q  <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && last_task_i) begin
          if ((count_q == '0) && !store_en) state_d = ST_EMPTY;
          else state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == count_q) state_d = ST_PICK;
      end
      ST_PICK: begin
        if (!found_q) begin
          state_d = (filled_q == '0) ? ST_EMPTY : ST_EMIT;
        end else if (slot_q + 1'b1 == count_q) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_EMIT: begin
        if (emit_last) state_d = ST_IDLE;
      end
      ST_EMPTY: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      slot_q   <= '0;
      filled_q <= '0;
      scan_q   <= '0;
      emit_q   <= '0;
      rd_v_q   <= 1'b0;
      found_q  <= 1'b0;
      strobe_q <= 1'b0;
      final_q  <= 1'b0;
      empty_q  <= 1'b0;
    end else begin
      rd_v_q   <= scan_rd;
      strobe_q <= emit_rd || (state_q == ST_EMPTY);
      final_q  <= (emit_rd && emit_last) || (state_q == ST_EMPTY);
      empty_q  <= (state_q == ST_EMPTY);
      if (store_en) begin
        count_q <= count_q + 1'b1;
      end
      if (accept && last_task_i) begin
        slot_q   <= '0;
        filled_q <= '0;
        scan_q   <= '0;
        emit_q   <= '0;
        found_q  <= 1'b0;
      end
      if (scan_rd) begin
        scan_q <= scan_q + 1'b1;
      end
      if (cand_ok) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_PICK) begin
        scan_q  <= '0;
        found_q <= 1'b0;
        if (found_q) begin
          filled_q <= filled_q + 1'b1;
          slot_q   <= slot_q + 1'b1;
        end
      end
      if (emit_rd) begin
        emit_q <= emit_q + 1'b1;
      end
      // drop the task set once the run has been issued
      if ((state_q == ST_EMPTY) || (emit_rd && emit_last)) begin
        count_q <= '0;
      end
    end
  end

  assign task_ext  = {{OUT_W{1'b0}}, chosen_rd_q};
  assign count_ext = {{OUT_W{1'b0}}, filled_q};

  assign busy              = (state_q != ST_IDLE);
  assign result_strobe_o   = strobe_q;
  assign final_result_o    = final_q;
  assign task_number_o     = empty_q ? '0 : task_ext[OUT_W-1:0];
  assign scheduled_count_o = count_ext[OUT_W-1:0];

endmodule
